// File: hw/rtl/epg_pkg.sv
package epg_pkg;

	// Default rhythm length limit.
	localparam int MAX_STEPS_DEF = 32;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_DIV,
		S_DIVW,
		S_PLAN,
		S_AHEAD,
		S_BHEAD,
		S_BLOOP,
		S_MRD,
		S_MWR,
		S_FHEAD,
		S_FACC,
		S_DONE
	} state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic init_wr;
		logic init_one;
		logic rd;
		logic merge_wr;
		logic acc;
		logic clr_word;
		logic div_start;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic div_busy;
	} status_t;

endpackage

// File: hw/rtl/euclidean_pattern_generator.sv
// Euclidean rhythm generator. Each input beat (steps, fills) yields one output
// beat: pattern holds the rhythm with the first step at bit steps-1, and invalid
// is set (pattern zero) when fills is zero, fills exceeds steps, or steps exceeds
// MAX_STEPS. One request is worked at a time through a sequencer and a group
// store with one write and two read ports. A request walks the store to fill it,
// divides, merges groups (in interleaving rounds, or one pass per pulse on the
// even-spread shortcut) and walks the store again to concatenate the result. An
// invalid request goes straight to the done state. A finished result sits in an
// output register and the next request is taken while it waits.
module euclidean_pattern_generator #(
	parameter int MAX_STEPS = epg_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  steps,
	input  logic [5:0]  fills,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pattern,
	output logic        invalid
);
	import epg_pkg::*;

	localparam int AW = $clog2(MAX_STEPS);
	localparam int CW = $clog2(MAX_STEPS+1);

	cmd_t                 cmd;
	status_t              status;
	logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
	logic [CW-1:0]        dividend, divisor, quo, rem;
	logic [MAX_STEPS-1:0] word;
	logic [MAX_STEPS+31:0] word_ext;
	logic                 fin, fin_invalid, out_free;
	logic                 out_valid_q;
	logic [31:0]          pattern_q;
	logic                 invalid_q;

	epg_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.steps      (steps),
		.fills      (fills),
		.out_free   (out_free),
		.fin        (fin),
		.fin_invalid(fin_invalid),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.dividend   (dividend),
		.divisor    (divisor),
		.status     (status),
		.quo        (quo),
		.rem        (rem)
	);

	epg_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.dividend (dividend),
		.divisor  (divisor),
		.status   (status),
		.quo      (quo),
		.rem      (rem),
		.word     (word)
	);

	// Output register: loads when empty or being drained.
	assign out_free = !out_valid_q || out_ready;
	assign word_ext = {32'b0, word};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			pattern_q <= fin_invalid ? 32'b0 : word_ext[31:0];
			invalid_q <= fin_invalid;
		end
	end

	assign out_valid = out_valid_q;
	assign pattern   = pattern_q;
	assign invalid   = invalid_q;

endmodule

// File: hw/rtl/epg_datapath.sv
module epg_datapath #(
	parameter int MAX_STEPS = epg_pkg::MAX_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  epg_pkg::cmd_t                      cmd,
	input  logic [$clog2(MAX_STEPS)-1:0]       wr_addr,
	input  logic [$clog2(MAX_STEPS)-1:0]       rd_addr_a,
	input  logic [$clog2(MAX_STEPS)-1:0]       rd_addr_b,
	input  logic [$clog2(MAX_STEPS+1)-1:0]     dividend,
	input  logic [$clog2(MAX_STEPS+1)-1:0]     divisor,
	output epg_pkg::status_t                   status,
	output logic [$clog2(MAX_STEPS+1)-1:0]     quo,
	output logic [$clog2(MAX_STEPS+1)-1:0]     rem,
	output logic [MAX_STEPS-1:0]               word
);
	import epg_pkg::*;

	localparam int CW  = $clog2(MAX_STEPS+1);
	localparam int GW  = MAX_STEPS;
	localparam int LW  = $clog2(MAX_STEPS+1);
	localparam int DCW = $clog2(CW+1);

	// One group: its bits, its length (a zero group counts one bit), nonzero mark.
	typedef struct packed {
		logic [GW-1:0] val;
		logic [LW-1:0] len;
		logic          nz;
	} grp_t;

	// Concatenate lo under hi, lo taking its own length.
	function automatic grp_t join_grp(grp_t hi, grp_t lo);
		grp_t r;
		r.val = (hi.val << lo.len) | lo.val;
		r.len = hi.nz ? LW'(hi.len + lo.len) : lo.len;
		r.nz  = hi.nz | lo.nz;
		return r;
	endfunction

	grp_t          mem [MAX_STEPS];
	grp_t          rda_q;
	grp_t          rdb_q;
	grp_t          word_q;
	grp_t          init_g;
	logic [CW:0]   r_q;
	logic [CW-1:0] q_q;
	logic [CW-1:0] d_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW:0]   r_sh;

	// Group store: one write port, two registered read ports.
	always_comb begin
		init_g.val = GW'(cmd.init_one);
		init_g.len = LW'(1);
		init_g.nz  = cmd.init_one;
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			mem[wr_addr] <= init_g;
		end else if (cmd.merge_wr) begin
			mem[wr_addr] <= join_grp(rda_q, rdb_q);
		end
		if (cmd.rd) begin
			rda_q <= mem[rd_addr_a];
			rdb_q <= mem[rd_addr_b];
		end
	end

	// Result word accumulator.
	always_ff @(posedge clk) begin
		if (cmd.clr_word) begin
			word_q.val <= '0;
			word_q.len <= LW'(1);
			word_q.nz  <= 1'b0;
		end else if (cmd.acc) begin
			word_q <= join_grp(word_q, rda_q);
		end
	end

	assign word = word_q.val;

	// Restoring divider, one quotient bit per cycle.
	assign r_sh = {r_q[CW-1:0], q_q[CW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= DCW'(CW);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (dcnt_q != '0) begin
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				q_q <= {q_q[CW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[CW-2:0], 1'b0};
			end
		end
	end

	assign status.div_busy = (dcnt_q != '0);
	assign quo = q_q;
	assign rem = r_q[CW-1:0];

endmodule

// File: hw/rtl/epg_ctrl.sv
module epg_ctrl #(
	parameter int MAX_STEPS = epg_pkg::MAX_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [5:0]                         steps,
	input  logic [5:0]                         fills,
	input  logic                               out_free,
	output logic                               fin,
	output logic                               fin_invalid,
	output epg_pkg::cmd_t                      cmd,
	output logic [$clog2(MAX_STEPS)-1:0]       wr_addr,
	output logic [$clog2(MAX_STEPS)-1:0]       rd_addr_a,
	output logic [$clog2(MAX_STEPS)-1:0]       rd_addr_b,
	output logic [$clog2(MAX_STEPS+1)-1:0]     dividend,
	output logic [$clog2(MAX_STEPS+1)-1:0]     divisor,
	input  epg_pkg::status_t                   status,
	input  logic [$clog2(MAX_STEPS+1)-1:0]     quo,
	input  logic [$clog2(MAX_STEPS+1)-1:0]     rem
);
	import epg_pkg::*;

	localparam int AW         = $clog2(MAX_STEPS);
	localparam int CW         = $clog2(MAX_STEPS+1);
	localparam int LOOP_LIMIT = 4 * MAX_STEPS + 4;
	localparam int IW         = $clog2(LOOP_LIMIT+1);

	state_t        state_q, state_d, ret_q, ret_d;
	logic [CW-1:0] n_q, n_d, k_q, k_d, count_q, count_d;
	logic [CW-1:0] ga_q, ga_d, gb_q, gb_d, a_q, a_d, j_q, j_d, t_q, t_d;
	logic [CW-1:0] dst_q, dst_d, src_q, src_d;
	logic [IW-1:0] iter_q, iter_d;
	logic          inv_q, inv_d;
	logic [CW:0]   src_w;
	logic [CW-1:0] dst_w;
	logic          ok_w;
	logic          req_bad;

	// Request check on the raw input fields.
	assign req_bad = (fills == 6'd0) || (fills > steps) ||
		(32'(steps) > 32'(MAX_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q     <= n_d;
		k_q     <= k_d;
		count_q <= count_d;
		ga_q    <= ga_d;
		gb_q    <= gb_d;
		a_q     <= a_d;
		j_q     <= j_d;
		t_q     <= t_d;
		dst_q   <= dst_d;
		src_q   <= src_d;
		iter_q  <= iter_d;
		inv_q   <= inv_d;
	end

	// Merge source counts down from the last live group; it must stay in range.
	always_comb begin
		dst_w = (state_q == S_AHEAD) ? a_q : j_q;
		src_w = {1'b0, count_q} - (CW+1)'(1) - {1'b0, j_q};
		ok_w  = !src_w[CW] && (src_w[CW-1:0] < count_q) && (dst_w < count_q);
	end

	// Sequencer: next state, counters and datapath commands.
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		n_d      = n_q;
		k_d      = k_q;
		count_d  = count_q;
		ga_d     = ga_q;
		gb_d     = gb_q;
		a_d      = a_q;
		j_d      = j_q;
		t_d      = t_q;
		dst_d    = dst_q;
		src_d    = src_q;
		iter_d   = iter_q;
		inv_d    = inv_q;
		cmd      = '0;
		in_ready = 1'b0;
		fin      = 1'b0;
		wr_addr  = dst_q[AW-1:0];
		rd_addr_a = dst_q[AW-1:0];
		rd_addr_b = src_q[AW-1:0];
		cmd.init_one = (a_q < k_q);

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					inv_d = req_bad;
					n_d   = CW'(steps);
					k_d   = CW'(fills);
					a_d   = '0;
					state_d = req_bad ? S_DONE : S_INIT;
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				wr_addr = a_q[AW-1:0];
				a_d = a_q + 1'b1;
				if (a_q == n_q - 1'b1) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (!status.div_busy) begin
					state_d = S_PLAN;
				end
			end
			S_PLAN: begin
				count_d = n_q;
				a_d = '0;
				j_d = '0;
				ga_d = k_q;
				gb_d = n_q - k_q;
				iter_d = '0;
				if (quo != '0 && rem < CW'(2)) begin
					state_d = S_AHEAD;
				end else begin
					state_d = S_BHEAD;
				end
			end
			// Each pulse takes the trailing pauses in one pass.
			S_AHEAD: begin
				if (a_q < k_q) begin
					if (j_q < quo) begin
						dst_d = a_q;
						src_d = src_w[CW-1:0];
						j_d = j_q + 1'b1;
						if (ok_w) begin
							ret_d = S_AHEAD;
							state_d = S_MRD;
						end
					end else begin
						count_d = count_q - quo;
						a_d = a_q + 1'b1;
						j_d = '0;
					end
				end else begin
					a_d = '0;
					cmd.clr_word = 1'b1;
					state_d = S_FHEAD;
				end
			end
			// One interleaving round (merge count, new group counts), else on to concatenation.
			S_BHEAD: begin
				if (gb_q > CW'(1) && iter_q < IW'(LOOP_LIMIT)) begin
					j_d = '0;
					if (ga_q > gb_q) begin
						t_d  = gb_q;
						ga_d = gb_q;
						gb_d = ga_q - gb_q;
					end else if (gb_q > ga_q) begin
						t_d  = (count_q > gb_q) ? count_q - gb_q : '0;
						gb_d = gb_q - ga_q;
					end else begin
						t_d  = ga_q;
						gb_d = '0;
					end
					state_d = S_BLOOP;
				end else begin
					a_d = '0;
					cmd.clr_word = 1'b1;
					state_d = S_FHEAD;
				end
			end
			S_BLOOP: begin
				if (j_q < t_q) begin
					dst_d = j_q;
					src_d = src_w[CW-1:0];
					j_d = j_q + 1'b1;
					if (ok_w) begin
						ret_d = S_BLOOP;
						state_d = S_MRD;
					end
				end else begin
					count_d = count_q - t_q;
					iter_d = iter_q + 1'b1;
					state_d = S_BHEAD;
				end
			end
			S_MRD: begin
				cmd.rd = 1'b1;
				state_d = S_MWR;
			end
			S_MWR: begin
				cmd.merge_wr = 1'b1;
				state_d = ret_q;
			end
			// Concatenate the surviving groups into the result word.
			S_FHEAD: begin
				if (a_q < count_q) begin
					cmd.rd = 1'b1;
					rd_addr_a = a_q[AW-1:0];
					state_d = S_FACC;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FACC: begin
				cmd.acc = 1'b1;
				a_d = a_q + 1'b1;
				state_d = S_FHEAD;
			end
			S_DONE: begin
				if (out_free) begin
					fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign fin_invalid = inv_q;
	assign dividend = n_q - k_q;
	assign divisor  = k_q;

endmodule
